### rtl/pds_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the periodic deadline scheduler
// no dependencies

package pds_pkg;

  localparam int TASK_SLOTS_DEF = 16;

  localparam logic [62:0] MAX63 = {63{1'b1}};
  localparam logic [29:0] RESET_PREPLAY = 30'd100;
  localparam logic [39:0] RESET_OVERRUN_LIMIT = 40'd300000;

  // request kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // lateness policies
  localparam logic [1:0] POL_REPLAY   = 2'd0;
  localparam logic [1:0] POL_PUSHBACK = 2'd1;
  localparam logic [1:0] POL_SKIP     = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PREPLAY = 2'd0;
  localparam logic [1:0] REG_LIMIT   = 2'd1;
  localparam logic [1:0] REG_AT_ONCE = 2'd2;

  typedef struct packed {
    logic [1:0]  policy;
    logic [62:0] period;
    logic [62:0] deadline;
    logic [7:0]  ident;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_START,
    ST_INS_EV,
    ST_INS_PUT,
    ST_REM_EV,
    ST_TICK_EV,
    ST_DEL_EV,
    ST_RESCHED,
    ST_DIV,
    ST_HEAD_RD,
    ST_HEAD_EV,
    ST_FINISH
  } state_t;

  // saturating 63-bit add
  function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? MAX63 : s[62:0];
  endfunction

endpackage

### rtl/pds_rem.sv
`timescale 1ns / 1ps
// restoring remainder unit, one quotient bit per cycle
// depends on nothing

module pds_rem (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] dividend,
  input  logic [62:0] divisor,
  output logic        done,
  output logic [62:0] rem
);

  logic        active;
  logic [5:0]  cnt;
  logic [62:0] dvd;
  logic [62:0] den;
  logic [63:0] trial;

  assign trial = {rem, dvd[62]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd62) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      den <= divisor;
    end else if (active) begin
      dvd <= {dvd[61:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= 63'(trial - {1'b0, den});
      end else begin
        rem <= trial[62:0];
      end
    end
  end

endmodule

### rtl/periodic_deadline_scheduler_unit.sv
`timescale 1ns / 1ps
// periodic deadline scheduler top level: slot memory, sequencer, output register
// depends on pds_pkg and pds_rem

// One request is taken at a time and yields one result beat. The task table
// sits in a single-port-read, single-port-write memory kept sorted by
// deadline, and every walk moves one slot per cycle. A tick that fires a
// skip-policy task that is late also runs the remainder unit. Configuration
// writes are always taken.

module periodic_deadline_scheduler_unit #(
  parameter int TASK_SLOTS = pds_pkg::TASK_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // task_ident[7:0], start_time[70:8], start_delay[133:71], period[196:134],
  // policy[198:197], now[261:199], zero fill
  input  logic [263:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // fired[0], fired_task[8:1], retired[9], found[10], table_full[11],
  // overrun_total[43:12], next_deadline[106:44], zero fill
  output logic [111:0] m_tdata,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [39:0]  cfg_data
);

  import pds_pkg::*;

  localparam int IDXW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNTW = IDXW + 1;
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(TASK_SLOTS);

  // request fields
  logic [7:0]  in_ident;
  logic [62:0] in_start_time, in_start_delay, in_period, in_now;
  logic [1:0]  in_policy;

  assign in_ident       = s_tdata[7:0];
  assign in_start_time  = s_tdata[70:8];
  assign in_start_delay = s_tdata[133:71];
  assign in_period      = s_tdata[196:134];
  assign in_policy      = s_tdata[198:197];
  assign in_now         = s_tdata[261:199];

  // configuration
  logic [29:0] preplay_window;
  logic [39:0] overrun_limit;
  logic        fire_at_once;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      preplay_window <= RESET_PREPLAY;
      overrun_limit  <= RESET_OVERRUN_LIMIT;
      fire_at_once   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PREPLAY: preplay_window <= cfg_data[29:0];
        REG_LIMIT:   overrun_limit  <= cfg_data;
        REG_AT_ONCE: fire_at_once   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // slot memory
  slot_t mem [TASK_SLOTS];
  slot_t rdata, wd;
  logic  rd_en, we;
  logic [IDXW-1:0] rd_addr, wa;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // sequencer state and working registers
  state_t state, state_next;
  logic [CNTW-1:0] used;
  logic [CNTW-1:0] used_m1_w;
  logic [IDXW-1:0] used_m1;
  logic [IDXW-1:0] idx;
  logic [1:0]  req_kind;
  logic [7:0]  req_ident;
  logic [62:0] req_now;
  slot_t       ins;
  logic [62:0] head_dl;
  logic        found_flag;
  logic [31:0] overrun_count;
  logic        res_fired, res_retired, res_full;
  logic [7:0]  res_task;
  logic [62:0] res_nd;
  logic        accept;

  assign used_m1_w = used - 1'b1;
  assign used_m1   = used_m1_w[IDXW-1:0];
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);

  // tick evaluation on the head slot
  logic        fire, overrun;
  logic [63:0] due_limit;
  logic [62:0] late;

  assign due_limit = {1'b0, req_now} + {34'b0, preplay_window};
  assign late      = req_now - rdata.deadline;
  assign fire      = fire_at_once || ({1'b0, rdata.deadline} <= due_limit);
  assign overrun   = (rdata.deadline != '0) && (req_now > rdata.deadline) &&
                     (late > {23'b0, overrun_limit}) && (overrun_count != '1);

  // rescheduling of the fired task
  logic [62:0] dl0, resched_dl;
  logic        skip_late;
  logic        div_start, div_done;
  logic [62:0] div_rem;

  assign dl0       = (head_dl == '0) ? req_now : head_dl;
  assign skip_late = (ins.policy == POL_SKIP) && (dl0 <= req_now);
  assign resched_dl = (ins.policy == POL_PUSHBACK) ? sat_add63(req_now, ins.period)
                                                   : sat_add63(dl0, ins.period);
  assign div_start = (state == ST_RESCHED) && (ins.period != '0) && skip_late;

  pds_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req_now - dl0),
    .divisor  (ins.period),
    .done     (div_done),
    .rem      (div_rem)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    we         = 1'b0;
    wa         = '0;
    wd         = rdata;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser) inside
            KIND_ADD: begin
              state_next = (used == FULL_CNT) ? ST_HEAD_RD : ST_INS_START;
            end
            KIND_REMOVE, KIND_TICK: begin
              if (used == '0) begin
                state_next = ST_HEAD_RD;
              end else begin
                rd_en      = 1'b1;
                state_next = (s_tuser == KIND_TICK) ? ST_TICK_EV : ST_REM_EV;
              end
            end
            default: state_next = ST_HEAD_RD;
          endcase
        end
      end
      ST_INS_START: begin
        if (used == '0) begin
          we         = 1'b1;
          wd         = ins;
          state_next = ST_HEAD_RD;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = used_m1;
          state_next = ST_INS_EV;
        end
      end
      ST_INS_EV: begin
        we = 1'b1;
        wa = idx + 1'b1;
        if (rdata.deadline > ins.deadline) begin
          if (idx == '0) begin
            state_next = ST_INS_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx - 1'b1;
          end
        end else begin
          wd         = ins;
          state_next = ST_HEAD_RD;
        end
      end
      ST_INS_PUT: begin
        we         = 1'b1;
        wd         = ins;
        state_next = ST_HEAD_RD;
      end
      ST_REM_EV: begin
        if (found_flag) begin
          we = 1'b1;
          wa = idx - 1'b1;
        end
        if (idx == used_m1) begin
          state_next = ST_HEAD_RD;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx + 1'b1;
        end
      end
      ST_TICK_EV: begin
        if (!fire) begin
          state_next = ST_HEAD_RD;
        end else if (used == CNTW'(1)) begin
          state_next = ST_RESCHED;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = IDXW'(1);
          state_next = ST_DEL_EV;
        end
      end
      ST_DEL_EV: begin
        we = 1'b1;
        wa = idx - 1'b1;
        if (idx == used_m1) begin
          state_next = ST_RESCHED;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx + 1'b1;
        end
      end
      ST_RESCHED: begin
        if (ins.period == '0) begin
          state_next = ST_HEAD_RD;
        end else if (skip_late) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_INS_START;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_INS_START;
        end
      end
      ST_HEAD_RD: begin
        if (used == '0) begin
          state_next = ST_FINISH;
        end else begin
          rd_en      = 1'b1;
          state_next = ST_HEAD_EV;
        end
      end
      ST_HEAD_EV: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      overrun_count <= '0;
      found_flag    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // result beat: load when the register is free or being emptied
      if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          found_flag <= 1'b0;
          if (accept && s_tuser == KIND_CLEAR) begin
            used <= '0;
          end
        end
        ST_INS_START: begin
          if (used == '0) begin
            used <= used + 1'b1;
          end
        end
        ST_INS_EV: begin
          if (rdata.deadline <= ins.deadline) begin
            used <= used + 1'b1;
          end
        end
        ST_INS_PUT: used <= used + 1'b1;
        ST_REM_EV: begin
          if (!found_flag && rdata.ident == req_ident) begin
            found_flag <= 1'b1;
          end
          if (idx == used_m1 && (found_flag || rdata.ident == req_ident)) begin
            used <= used - 1'b1;
          end
        end
        ST_TICK_EV: begin
          if (overrun) begin
            overrun_count <= overrun_count + 32'd1;
          end
          if (fire && used == CNTW'(1)) begin
            used <= '0;
          end
        end
        ST_DEL_EV: begin
          if (idx == used_m1) begin
            used <= used - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working data registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          req_kind    <= s_tuser;
          req_ident   <= in_ident;
          req_now     <= in_now;
          ins.ident   <= in_ident;
          ins.period  <= in_period;
          ins.policy  <= in_policy;
          ins.deadline <= (in_start_delay != '0) ? sat_add63(in_now, in_start_delay)
                                                 : in_start_time;
          res_fired   <= 1'b0;
          res_task    <= '0;
          res_retired <= 1'b0;
          res_full    <= (s_tuser == KIND_ADD) && (used == FULL_CNT);
          idx         <= '0;
        end
      end
      ST_INS_START: idx <= used_m1;
      ST_INS_EV: begin
        if (idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
      ST_REM_EV, ST_DEL_EV: begin
        if (idx != used_m1) begin
          idx <= idx + 1'b1;
        end
      end
      ST_TICK_EV: begin
        if (fire) begin
          res_fired  <= 1'b1;
          res_task   <= rdata.ident;
          ins.ident  <= rdata.ident;
          ins.period <= rdata.period;
          ins.policy <= rdata.policy;
          head_dl    <= rdata.deadline;
          idx        <= IDXW'(1);
        end
      end
      ST_RESCHED: begin
        if (ins.period == '0) begin
          res_retired <= 1'b1;
        end
        ins.deadline <= resched_dl;
      end
      ST_DIV: begin
        if (div_done) begin
          ins.deadline <= sat_add63(req_now - div_rem, ins.period);
        end
      end
      ST_HEAD_RD: begin
        if (used == '0) begin
          res_nd <= '0;
        end
      end
      ST_HEAD_EV: res_nd <= rdata.deadline;
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {5'b0, res_nd, overrun_count, res_full,
                      (req_kind == KIND_REMOVE) && found_flag,
                      res_retired, res_task, res_fired};
        end
      end
      default: ;
    endcase
  end

  // checks
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= FULL_CNT)
    else $error("slot count above table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == KIND_CLEAR) |=> (used == '0))
    else $error("clear left entries in the table");

  a_overrun_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (overrun_count >= $past(overrun_count)))
    else $error("overrun count went down");

  a_remove_keeps_or_drops_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REM_EV && state_next == ST_HEAD_RD) |=>
      (used == $past(used) || used == $past(used) - 1'b1))
    else $error("remove changed the table by more than one entry");

endmodule
